@@ rtl/core/dsc_pkg.sv @@
// Shared types and constants for the divisible subset counter.
`timescale 1ns / 1ps
package dsc_pkg;

	localparam int VALUE_W  = 32;
	localparam int CNT_W    = 64;
	localparam int CFG_W    = 6;
	localparam int DIV_W    = 6;
	localparam int GRP_W    = 5;
	localparam int STEP_W   = $clog2(VALUE_W);

	localparam logic [STEP_W-1:0] DIV_STEP_LAST = STEP_W'(VALUE_W - 1);

	typedef logic [0:0] reg_idx_t;
	localparam reg_idx_t REG_DIVISOR = 1'b0;
	localparam reg_idx_t REG_GROUP   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_FIX,
		ST_SWEEP,
		ST_DRAIN,
		ST_RES_RD,
		ST_RES_WAIT
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic fix;
		logic issue;
		logic result_rd;
		logic out_load;
		logic clear;
	} dsc_cmd_t;

	typedef struct packed {
		logic div_done;
		logic sweep_last;
	} dsc_sts_t;

endpackage

@@ rtl/core/dsc_datapath.sv @@
// Datapath: config registers, residue divider, count table and row sweep.
`timescale 1ns / 1ps
module dsc_datapath #(
	parameter int MAX_GROUP   = 16,
	parameter int MAX_DIVISOR = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  dsc_pkg::reg_idx_t             cfg_idx,
	input  logic [dsc_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [dsc_pkg::VALUE_W-1:0]   value,
	input  dsc_pkg::dsc_cmd_t             cmd,
	output dsc_pkg::dsc_sts_t             sts,
	output logic [dsc_pkg::CNT_W-1:0]     subset_count
);
	import dsc_pkg::*;

	localparam int KW    = (MAX_DIVISOR > 1) ? $clog2(MAX_DIVISOR) : 1;
	localparam int RW    = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
	localparam int DEPTH = MAX_GROUP * MAX_DIVISOR;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = ((KW > DIV_W) ? KW : DIV_W) + 1;

	localparam logic [DIV_W-1:0] DIV_CAP = DIV_W'((MAX_DIVISOR < 63) ? MAX_DIVISOR : 63);
	localparam logic [GRP_W-1:0] GRP_CAP = GRP_W'((MAX_GROUP < 31) ? MAX_GROUP : 31);
	localparam logic [KW-1:0]    K_LAST  = KW'(MAX_DIVISOR - 1);

	logic [DIV_W-1:0]   divisor_q;
	logic [GRP_W-1:0]   group_q;
	logic [DIV_W-1:0]   div_eff;
	logic [GRP_W-1:0]   grp_eff;

	logic [VALUE_W-1:0] mag_q;
	logic               neg_q;
	logic [DIV_W-1:0]   rem_q;
	logic [STEP_W-1:0]  step_q;
	logic [DIV_W:0]     trial;
	logic [DIV_W-1:0]   res_q;

	logic [GRP_W-1:0]   j_q;
	logic [KW-1:0]      k_q;
	logic [CW-1:0]      diff;
	logic [CW-1:0]      src_w;
	logic [KW-1:0]      src;
	logic [RW-1:0]      row_a;
	logic [RW-1:0]      row_b;
	logic [KW-1:0]      col_a;
	logic [AW-1:0]      addr_a;
	logic [AW-1:0]      addr_b;

	logic [CNT_W-1:0]   mem [DEPTH];
	logic [MAX_GROUP-1:0] row_vld_q;

	logic [CNT_W-1:0]   rd_a_s1;
	logic [CNT_W-1:0]   rd_b_s1;
	logic               wr_en_s1;
	logic [AW-1:0]      wr_addr_s1;
	logic [RW-1:0]      row_s1;
	logic               a_vld_s1;
	logic               b_vld_s1;
	logic               b_const_s1;
	logic               src_zero_s1;
	logic               add_en_s1;
	logic               set_vld_s1;

	logic [CNT_W-1:0]   a_val;
	logic [CNT_W-1:0]   b_val;
	logic [CNT_W-1:0]   sum;
	logic [CNT_W-1:0]   out_q;

	always_comb begin
		if (divisor_q == '0) begin
			div_eff = DIV_W'(1);
		end else if (divisor_q > DIV_CAP) begin
			div_eff = DIV_CAP;
		end else begin
			div_eff = divisor_q;
		end
		if (group_q == '0) begin
			grp_eff = GRP_W'(1);
		end else if (group_q > GRP_CAP) begin
			grp_eff = GRP_CAP;
		end else begin
			grp_eff = group_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= DIV_W'(1);
			group_q   <= GRP_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DIVISOR: divisor_q <= cfg_wdata[DIV_W-1:0];
				REG_GROUP:   group_q   <= cfg_wdata[GRP_W-1:0];
				default:     ;
			endcase
		end
	end

	assign trial = {rem_q, mag_q[VALUE_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= value[VALUE_W-1];
			mag_q  <= value[VALUE_W-1] ? (~value + VALUE_W'(1)) : value;
			rem_q  <= '0;
			step_q <= '0;
		end else if (cmd.div_step) begin
			mag_q  <= {mag_q[VALUE_W-2:0], 1'b0};
			step_q <= step_q + STEP_W'(1);
			if (trial >= {1'b0, div_eff}) begin
				rem_q <= DIV_W'(trial - {1'b0, div_eff});
			end else begin
				rem_q <= trial[DIV_W-1:0];
			end
		end
		if (cmd.fix) begin
			res_q <= (neg_q && rem_q != '0) ? div_eff - rem_q : rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= '0;
			k_q <= '0;
		end else if (cmd.load) begin
			j_q <= grp_eff;
			k_q <= '0;
		end else if (cmd.issue) begin
			if (k_q == K_LAST) begin
				k_q <= '0;
				j_q <= j_q - GRP_W'(1);
			end else begin
				k_q <= k_q + KW'(1);
			end
		end
	end

	assign sts.div_done   = (step_q == DIV_STEP_LAST);
	assign sts.sweep_last = (j_q == GRP_W'(1)) && (k_q == K_LAST);

	assign diff  = CW'(k_q) - CW'(res_q);
	assign src_w = diff[CW-1] ? diff + CW'(div_eff) : diff;
	assign src   = src_w[KW-1:0];

	assign row_a  = cmd.result_rd ? RW'(grp_eff - GRP_W'(1)) : RW'(j_q - GRP_W'(1));
	assign col_a  = cmd.result_rd ? '0 : k_q;
	assign row_b  = (j_q > GRP_W'(1)) ? RW'(j_q - GRP_W'(2)) : '0;
	assign addr_a = AW'(row_a) * AW'(MAX_DIVISOR) + AW'(col_a);
	assign addr_b = AW'(row_b) * AW'(MAX_DIVISOR) + AW'(src);

	always_ff @(posedge clk) begin
		rd_a_s1 <= mem[addr_a];
		rd_b_s1 <= mem[addr_b];
		if (wr_en_s1) begin
			mem[wr_addr_s1] <= sum;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1  <= addr_a;
		row_s1      <= row_a;
		a_vld_s1    <= row_vld_q[row_a];
		b_vld_s1    <= row_vld_q[row_b];
		b_const_s1  <= (j_q == GRP_W'(1));
		src_zero_s1 <= (src_w == '0);
		add_en_s1   <= (CW'(k_q) < CW'(div_eff));
		set_vld_s1  <= (k_q == K_LAST);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= cmd.issue;
		end
	end

	assign a_val = a_vld_s1 ? rd_a_s1 : '0;
	always_comb begin
		if (!add_en_s1) begin
			b_val = '0;
		end else if (b_const_s1) begin
			b_val = src_zero_s1 ? CNT_W'(1) : '0;
		end else begin
			b_val = b_vld_s1 ? rd_b_s1 : '0;
		end
	end
	assign sum = a_val + b_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (cmd.clear) begin
			row_vld_q <= '0;
		end else if (wr_en_s1 && set_vld_s1) begin
			row_vld_q[row_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= a_val;
		end
	end

	assign subset_count = out_q;

endmodule

@@ rtl/core/dsc_ctrl.sv @@
// Controller: request handshake, divide and sweep sequencing, result hand-off.
`timescale 1ns / 1ps
module dsc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               s_tlast,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  dsc_pkg::dsc_sts_t  sts,
	output dsc_pkg::dsc_cmd_t  cmd
);
	import dsc_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   last_q;
	logic   m_tvalid_q;
	logic   out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (s_tvalid) state_d = ST_DIVIDE;
			ST_DIVIDE:   if (sts.div_done) state_d = ST_FIX;
			ST_FIX:      state_d = ST_SWEEP;
			ST_SWEEP:    if (sts.sweep_last) state_d = ST_DRAIN;
			ST_DRAIN:    state_d = last_q ? ST_RES_RD : ST_IDLE;
			ST_RES_RD:   state_d = ST_RES_WAIT;
			ST_RES_WAIT: if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_DIVIDE: cmd.div_step = 1'b1;
			ST_FIX:    cmd.fix = 1'b1;
			ST_SWEEP:  cmd.issue = 1'b1;
			ST_DRAIN:  ;
			ST_RES_RD: cmd.result_rd = 1'b1;
			ST_RES_WAIT: begin
				cmd.result_rd = 1'b1;
				cmd.out_load  = out_free;
				cmd.clear     = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			last_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) begin
				last_q <= s_tlast;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

@@ rtl/core/divisible_subset_count_top.sv @@
// Top level of the divisible subset counter.
// Each request is accepted, then runs 32 divider steps, one residue fix, a sweep of one table
// entry per cycle over MAX_DIVISOR columns of each row, and one write drain.
// A request marked last then reads the count into the output register once the previous result is taken.
// A new request is accepted only after the previous one has finished and the controller is idle again.
// Asynchronous reset clears control state and all row valid bits, so the table reads as reset.
`timescale 1ns / 1ps
module divisible_subset_count_top #(
	parameter int MAX_GROUP   = 16,
	parameter int MAX_DIVISOR = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  dsc_pkg::reg_idx_t           cfg_idx,
	input  logic [dsc_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,   // value[31:0]
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [63:0]                 m_tdata    // subset_count[63:0]
);
	import dsc_pkg::*;

	dsc_cmd_t cmd;
	dsc_sts_t sts;

	dsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dsc_datapath #(
		.MAX_GROUP   (MAX_GROUP),
		.MAX_DIVISOR (MAX_DIVISOR)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.value        (s_tdata),
		.cmd          (cmd),
		.sts          (sts),
		.subset_count (m_tdata)
	);

endmodule

@@ rtl/core/dsc_checker.sv @@
// Port-level checker for the divisible subset counter, bound to the top level.
`timescale 1ns / 1ps
module dsc_sva_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [63:0]                 m_tdata
);

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready stayed high after a request");

	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while the block was idle");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid)
		else $error("result dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("result data changed while stalled");

endmodule

bind divisible_subset_count_top dsc_sva_checker u_dsc_sva_checker (.*);
